[hw/rtl/pmdp_pkg.sv]
// Shared types, constants and decode helpers for the packed mixed dot product.
package pmdp_pkg;

  localparam int unsigned LANES_DEFAULT     = 4;
  localparam int unsigned ACC_WIDTH_DEFAULT = 32;
  localparam int unsigned WORD_W            = 64;
  localparam int unsigned ELEM_MAX_W        = 16;
  localparam int unsigned PROD_W            = 2 * ELEM_MAX_W;
  localparam int unsigned PAIR_MODE_W       = 4;
  localparam int unsigned COUNT_W           = 3;
  localparam int unsigned SUM_W             = 32;
  localparam int unsigned MID_DEPTH         = 4;
  localparam int unsigned OUT_DEPTH         = 4;

  typedef enum logic [PAIR_MODE_W-1:0] {
    MODE_16X16 = 4'd0,
    MODE_8X8   = 4'd1,
    MODE_4X4   = 4'd2,
    MODE_2X2   = 4'd3,
    MODE_16X8  = 4'd4,
    MODE_16X4  = 4'd5,
    MODE_16X2  = 4'd6,
    MODE_8X4   = 4'd7,
    MODE_8X2   = 4'd8,
    MODE_4X2   = 4'd9
  } pair_mode_e;

  typedef enum logic [1:0] {
    ELEM_W16,
    ELEM_W8,
    ELEM_W4,
    ELEM_W2
  } elem_width_e;

  typedef struct packed {
    logic        ok;
    elem_width_e a_w;
    elem_width_e b_w;
  } mode_decode_t;

  function automatic mode_decode_t decode_mode(logic [PAIR_MODE_W-1:0] mode);
    mode_decode_t r;
    r.ok  = 1'b1;
    r.a_w = ELEM_W16;
    r.b_w = ELEM_W16;
    case (mode)
      MODE_16X16: begin r.a_w = ELEM_W16; r.b_w = ELEM_W16; end
      MODE_8X8:   begin r.a_w = ELEM_W8;  r.b_w = ELEM_W8;  end
      MODE_4X4:   begin r.a_w = ELEM_W4;  r.b_w = ELEM_W4;  end
      MODE_2X2:   begin r.a_w = ELEM_W2;  r.b_w = ELEM_W2;  end
      MODE_16X8:  begin r.a_w = ELEM_W16; r.b_w = ELEM_W8;  end
      MODE_16X4:  begin r.a_w = ELEM_W16; r.b_w = ELEM_W4;  end
      MODE_16X2:  begin r.a_w = ELEM_W16; r.b_w = ELEM_W2;  end
      MODE_8X4:   begin r.a_w = ELEM_W8;  r.b_w = ELEM_W4;  end
      MODE_8X2:   begin r.a_w = ELEM_W8;  r.b_w = ELEM_W2;  end
      MODE_4X2:   begin r.a_w = ELEM_W4;  r.b_w = ELEM_W2;  end
      default:    r.ok = 1'b0;
    endcase
    return r;
  endfunction

  // Sign-extended element of one lane; an element that does not fit in the word reads as zero.
  function automatic logic signed [ELEM_MAX_W-1:0] extract_elem(
    logic [WORD_W-1:0] word,
    elem_width_e       w,
    int unsigned       lane
  );
    logic signed [ELEM_MAX_W-1:0] r;
    r = '0;
    case (w)
      ELEM_W16: begin
        if ((lane + 1) * 16 <= WORD_W) r = ELEM_MAX_W'($signed(word[lane*16 +: 16]));
      end
      ELEM_W8: begin
        if ((lane + 1) * 8 <= WORD_W) r = ELEM_MAX_W'($signed(word[lane*8 +: 8]));
      end
      ELEM_W4: begin
        if ((lane + 1) * 4 <= WORD_W) r = ELEM_MAX_W'($signed(word[lane*4 +: 4]));
      end
      ELEM_W2: begin
        if ((lane + 1) * 2 <= WORD_W) r = ELEM_MAX_W'($signed(word[lane*2 +: 2]));
      end
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/pmdp_fifo.sv]
// Small register-based queue used between the front and back and for finished sums.
module pmdp_fifo #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           wr_data_i,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           rd_data_o,
  output logic                       full_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o    = (count_q == CNT_W'(DEPTH));
  assign empty_o   = (count_q == '0);
  assign count_o   = count_q;
  assign rd_data_o = mem_q[rd_ptr_q];
  assign do_push   = push_i & ~full_o;
  assign do_pop    = pop_i & ~empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

[hw/rtl/pmdp_front.sv]
// Front end: holds the pair mode and unpacks each accepted beat into sign-extended lane elements.
module pmdp_front #(
  parameter int unsigned LANES = pmdp_pkg::LANES_DEFAULT
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  logic [pmdp_pkg::PAIR_MODE_W-1:0]         cfg_data_i,
  input  logic                                     push_i,
  input  logic [pmdp_pkg::WORD_W-1:0]              a_bits_i,
  input  logic [pmdp_pkg::WORD_W-1:0]              b_bits_i,
  input  logic [pmdp_pkg::COUNT_W-1:0]             valid_count_i,
  input  logic                                     last_i,
  input  logic                                     mid_full_i,
  output logic                                     mid_push_o,
  output logic [2*LANES*pmdp_pkg::ELEM_MAX_W:0]    mid_data_o
);

  import pmdp_pkg::*;

  localparam int unsigned FLAT_W = LANES * ELEM_MAX_W;

  logic [PAIR_MODE_W-1:0] pair_mode_q;
  mode_decode_t           dec;
  logic [FLAT_W-1:0]      a_flat, b_flat;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_mode_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      pair_mode_q <= cfg_data_i;
    end
  end

  assign dec = decode_mode(pair_mode_q);

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    logic lane_on;
    // A lane counts when it lies below the beat's count; an undefined mode zeroes every lane.
    assign lane_on = dec.ok && ({2'b00, valid_count_i} > 5'(i));
    assign a_flat[i*ELEM_MAX_W +: ELEM_MAX_W] =
      lane_on ? extract_elem(a_bits_i, dec.a_w, i) : '0;
    assign b_flat[i*ELEM_MAX_W +: ELEM_MAX_W] =
      lane_on ? extract_elem(b_bits_i, dec.b_w, i) : '0;
  end

  assign mid_push_o = push_i & ~mid_full_i;
  assign mid_data_o = {last_i, b_flat, a_flat};

endmodule

[hw/rtl/pmdp_back.sv]
// Back end: lane multipliers, lane adder, accumulator and the queue of finished sums.
module pmdp_back #(
  parameter int unsigned LANES     = pmdp_pkg::LANES_DEFAULT,
  parameter int unsigned ACC_WIDTH = pmdp_pkg::ACC_WIDTH_DEFAULT
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  mid_empty_i,
  input  logic [2*LANES*pmdp_pkg::ELEM_MAX_W:0] mid_data_i,
  output logic                                  mid_pop_o,
  input  logic                                  pop,
  output logic                                  empty,
  output logic signed [pmdp_pkg::SUM_W-1:0]     dot_sum_o
);

  import pmdp_pkg::*;

  localparam int unsigned FLAT_W   = LANES * ELEM_MAX_W;
  localparam int unsigned OCNT_W   = $clog2(OUT_DEPTH + 1);
  localparam int unsigned CREDIT_W = OCNT_W + 1;

  logic signed [PROD_W-1:0]    prod_d [LANES];
  logic signed [PROD_W-1:0]    prod_q [LANES];
  logic                        v1_q, last1_q;
  logic [ACC_WIDTH-1:0]        lane_sum_d, sum_q;
  logic                        v2_q, last2_q;
  logic [ACC_WIDTH-1:0]        acc_q, acc_d, acc_next;
  logic                        out_push, out_full;
  logic [SUM_W-1:0]            out_data, out_rd;
  logic [OCNT_W-1:0]           out_count;
  logic [CREDIT_W-1:0]         credit_used;
  logic [FLAT_W-1:0]           a_flat, b_flat;
  logic                        mid_last;

  assign {mid_last, b_flat, a_flat} = mid_data_i;

  // Every beat in flight may end in a sum, so room is reserved before a beat leaves the queue.
  assign credit_used = CREDIT_W'(out_count) + CREDIT_W'(v1_q) + CREDIT_W'(v2_q);
  assign mid_pop_o   = ~mid_empty_i && (credit_used < CREDIT_W'(OUT_DEPTH));

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      prod_d[i] = $signed(a_flat[i*ELEM_MAX_W +: ELEM_MAX_W])
                * $signed(b_flat[i*ELEM_MAX_W +: ELEM_MAX_W]);
    end
  end

  always_comb begin
    lane_sum_d = '0;
    for (int i = 0; i < LANES; i++) begin
      lane_sum_d = lane_sum_d + ACC_WIDTH'(prod_q[i]);
    end
  end

  assign acc_next = acc_q + sum_q;
  assign acc_d    = !v2_q ? acc_q : (last2_q ? '0 : acc_next);
  assign out_push = v2_q & last2_q;
  assign out_data = SUM_W'($signed(acc_next));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      last1_q <= 1'b0;
      v2_q    <= 1'b0;
      last2_q <= 1'b0;
      acc_q   <= '0;
    end else begin
      v1_q    <= mid_pop_o;
      last1_q <= mid_last;
      v2_q    <= v1_q;
      last2_q <= last1_q;
      acc_q   <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    sum_q  <= lane_sum_d;
  end

  pmdp_fifo #(
    .WIDTH (SUM_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (out_push),
    .wr_data_i (out_data),
    .pop_i     (pop),
    .rd_data_o (out_rd),
    .full_o    (out_full),
    .empty_o   (empty),
    .count_o   (out_count)
  );

  assign dot_sum_o = $signed(out_rd);

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push |-> !out_full)
    else $error("finished sum pushed into a full result queue");

  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    credit_used <= CREDIT_W'(OUT_DEPTH))
    else $error("beats in flight exceed the result queue room");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && last2_q) |=> (acc_q == '0))
    else $error("accumulator not cleared after the last beat");

  a_pipe_follows_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_pop_o |=> v1_q ##1 v2_q)
    else $error("popped beat lost in the multiply or add stage");
`endif

endmodule

[hw/rtl/packed_mixed_dot_product.sv]
// Top level of the packed mixed-precision integer dot product.
//
// Input channel: a beat carries a_bits_i, b_bits_i, valid_count_i and last_i and is taken
// at a clock edge with push high and full low. Result channel: while empty is low,
// dot_sum_o holds the oldest finished sum; it is taken at an edge with pop high.
// The pair mode is written over cfg_valid_i/cfg_data_i; cfg_ready_o is always high.
// One beat is taken per cycle while full is low. A sum passes from the edge that takes its
// last beat through the input queue, the lane multiplier registers and the lane adder
// register, with the accumulate feeding the result queue.
// The back end pulls a beat only when the four-entry result queue has room for every
// beat in flight, so a stalled receiver first fills the result queue, then the
// four-entry input queue, and then raises full; nothing is dropped.
// Reset clears the pair mode to 16x16, empties both queues and zeroes the accumulator.
module packed_mixed_dot_product #(
  parameter int unsigned LANES     = pmdp_pkg::LANES_DEFAULT,
  parameter int unsigned ACC_WIDTH = pmdp_pkg::ACC_WIDTH_DEFAULT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [pmdp_pkg::PAIR_MODE_W-1:0]  cfg_data_i,
  input  logic                              push,
  output logic                              full,
  input  logic [pmdp_pkg::WORD_W-1:0]       a_bits_i,
  input  logic [pmdp_pkg::WORD_W-1:0]       b_bits_i,
  input  logic [pmdp_pkg::COUNT_W-1:0]      valid_count_i,
  input  logic                              last_i,
  input  logic                              pop,
  output logic                              empty,
  output logic signed [pmdp_pkg::SUM_W-1:0] dot_sum_o
);

  import pmdp_pkg::*;

  localparam int unsigned MID_W = 2 * LANES * ELEM_MAX_W + 1;

  logic             mid_push, mid_pop, mid_full, mid_empty;
  logic [MID_W-1:0] mid_wr, mid_rd;

  pmdp_front #(
    .LANES (LANES)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .push_i        (push),
    .a_bits_i      (a_bits_i),
    .b_bits_i      (b_bits_i),
    .valid_count_i (valid_count_i),
    .last_i        (last_i),
    .mid_full_i    (mid_full),
    .mid_push_o    (mid_push),
    .mid_data_o    (mid_wr)
  );

  pmdp_fifo #(
    .WIDTH (MID_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (mid_push),
    .wr_data_i (mid_wr),
    .pop_i     (mid_pop),
    .rd_data_o (mid_rd),
    .full_o    (mid_full),
    .empty_o   (mid_empty),
    .count_o   ()
  );

  assign full = mid_full;

  pmdp_back #(
    .LANES     (LANES),
    .ACC_WIDTH (ACC_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_empty_i (mid_empty),
    .mid_data_i  (mid_rd),
    .mid_pop_o   (mid_pop),
    .pop         (pop),
    .empty       (empty),
    .dot_sum_o   (dot_sum_o)
  );

endmodule

[verif/packed_mixed_dot_product_tb.sv]
// Self-checking testbench for the packed mixed-precision dot product.
`timescale 1ns / 100ps

module packed_mixed_dot_product_tb;
  import pmdp_pkg::*;

  localparam logic [PAIR_MODE_W-1:0] MODE_UNDEF_LO = 4'd10;
  localparam logic [PAIR_MODE_W-1:0] MODE_UNDEF_HI = 4'd15;
  localparam int unsigned DRAIN_CYCLES = 16;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [PAIR_MODE_W-1:0]   cfg_data_i;
  logic                     push;
  logic                     full;
  logic [WORD_W-1:0]        a_bits_i;
  logic [WORD_W-1:0]        b_bits_i;
  logic [COUNT_W-1:0]       valid_count_i;
  logic                     last_i;
  logic                     pop = 1'b0;
  logic                     empty;
  logic signed [SUM_W-1:0]  dot_sum_o;

  // Predictor state: the configured pair mode and the running accumulator.
  logic [PAIR_MODE_W-1:0]   pair_mode_q;
  logic [SUM_W-1:0]         running_sum_q;
  logic signed [SUM_W-1:0]  expected_sums[$];

  int send_idle_pct;
  int recv_idle_pct;
  int fail_count;
  int beats_sent;
  int sums_checked;
  int mode_writes;

  packed_mixed_dot_product dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .push          (push),
    .full          (full),
    .a_bits_i      (a_bits_i),
    .b_bits_i      (b_bits_i),
    .valid_count_i (valid_count_i),
    .last_i        (last_i),
    .pop           (pop),
    .empty         (empty),
    .dot_sum_o     (dot_sum_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("Timeout at %0t with %0d sums outstanding.", $time, expected_sums.size());
    $display("packed_mixed_dot_product regression: fail");
    $finish;
  end

  function automatic void mode_widths(input logic [PAIR_MODE_W-1:0] m,
                                      output int unsigned wa, output int unsigned wb,
                                      output bit known);
    known = 1'b1;
    wa = 0;
    wb = 0;
    case (m)
      MODE_16X16: begin wa = 16; wb = 16; end
      MODE_8X8:   begin wa = 8;  wb = 8;  end
      MODE_4X4:   begin wa = 4;  wb = 4;  end
      MODE_2X2:   begin wa = 2;  wb = 2;  end
      MODE_16X8:  begin wa = 16; wb = 8;  end
      MODE_16X4:  begin wa = 16; wb = 4;  end
      MODE_16X2:  begin wa = 16; wb = 2;  end
      MODE_8X4:   begin wa = 8;  wb = 4;  end
      MODE_8X2:   begin wa = 8;  wb = 2;  end
      MODE_4X2:   begin wa = 4;  wb = 2;  end
      default:    known = 1'b0;
    endcase
  endfunction

  // Two's complement element of one lane; an element past the end of the word is zero.
  function automatic longint lane_elem(logic [WORD_W-1:0] word, int unsigned w,
                                       int unsigned lane);
    logic [WORD_W-1:0] raw;
    if ((lane + 1) * w > WORD_W) return 0;
    raw = (word >> (lane * w)) & ((64'd1 << w) - 64'd1);
    if (raw[w-1]) return longint'(raw) - (longint'(1) << w);
    return longint'(raw);
  endfunction

  // Word with only the sign bit of every element set, i.e. every element at its minimum.
  function automatic logic [WORD_W-1:0] sign_bits_word(int unsigned w);
    logic [WORD_W-1:0] word;
    word = '0;
    for (int unsigned i = 0; (i + 1) * w <= WORD_W; i++) word[i*w + w - 1] = 1'b1;
    return word;
  endfunction

  function automatic logic [WORD_W-1:0] rand_word(int unsigned w);
    case ($urandom_range(0, 9))
      0:       return sign_bits_word(w);
      1:       return ~sign_bits_word(w);
      2:       return '1;
      3:       return '0;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic accumulate_beat(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b,
                                 logic [COUNT_W-1:0] cnt, logic lst);
    int unsigned wa, wb, n;
    bit known;
    mode_widths(pair_mode_q, wa, wb, known);
    n = (cnt > LANES_DEFAULT) ? LANES_DEFAULT : cnt;
    if (known) begin
      for (int unsigned i = 0; i < n; i++)
        running_sum_q = running_sum_q + SUM_W'(lane_elem(a, wa, i) * lane_elem(b, wb, i));
    end
    if (lst) begin
      expected_sums.push_back(running_sum_q);
      running_sum_q = '0;
    end
  endtask

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_beat(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b,
                           logic [COUNT_W-1:0] cnt, logic lst);
    // Each cycle idles with the set chance, so the idle share matches the percentage.
    while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push          <= 1'b1;
    a_bits_i      <= a;
    b_bits_i      <= b;
    valid_count_i <= cnt;
    last_i        <= lst;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    accumulate_beat(a, b, cnt, lst);
    beats_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain_pipeline();
    push <= 1'b0;
    while (expected_sums.size() != 0) @(negedge clk_i);
    // Beats without last give no sum, so allow them time to clear the queue and lanes.
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_pair_mode(logic [PAIR_MODE_W-1:0] m);
    drain_pipeline();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= m;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    pair_mode_q = m;
    mode_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Receiver side: pop at random, at the rate set for the current phase.
  always @(negedge clk_i) begin
    pop <= rst_ni && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin : check_sum
    logic signed [SUM_W-1:0] want;
    if (rst_ni && pop && !empty) begin
      if (expected_sums.size() == 0) begin
        $display("%0t: unexpected dot_sum beat, actual %0d", $time, dot_sum_o);
        fail_count++;
      end else begin
        want = expected_sums.pop_front();
        sums_checked++;
        if (dot_sum_o !== want) begin
          $display("%0t: dot_sum mismatch, expected %0d actual %0d", $time, want, dot_sum_o);
          fail_count++;
        end
      end
    end
  end

  task automatic test_reset_default();
    send_beat({$urandom, $urandom}, {$urandom, $urandom}, 3'd4, 1'b1);
  endtask

  task automatic test_each_pair_mode();
    int unsigned wa, wb;
    bit known;
    for (int m = MODE_16X16; m <= MODE_4X2; m++) begin
      write_pair_mode(PAIR_MODE_W'(m));
      mode_widths(PAIR_MODE_W'(m), wa, wb, known);
      send_beat(sign_bits_word(wa), sign_bits_word(wb), 3'd4, 1'b1);
    end
  endtask

  task automatic test_operand_extremes();
    write_pair_mode(MODE_16X16);
    send_beat('0, '0, 3'd4, 1'b1);
    send_beat('1, '1, 3'd4, 1'b1);
    // A count above the lane total saturates; the next beat has no counted lanes.
    send_beat(~sign_bits_word(16), sign_bits_word(16), 3'd7, 1'b0);
    send_beat({$urandom, $urandom}, {$urandom, $urandom}, 3'd0, 1'b1);
    // Four products of 2^30 wrap the accumulator back to zero.
    send_beat(sign_bits_word(16), sign_bits_word(16), 3'd4, 1'b1);
  endtask

  task automatic test_undefined_modes();
    send_beat({$urandom, $urandom}, {$urandom, $urandom}, 3'd3, 1'b0);
    write_pair_mode(MODE_UNDEF_HI);
    send_beat({$urandom, $urandom}, {$urandom, $urandom}, 3'd4, 1'b0);
    write_pair_mode(MODE_UNDEF_LO);
    send_beat({$urandom, $urandom}, {$urandom, $urandom}, 3'd4, 1'b1);
  endtask

  task automatic test_random_vectors(int sender_pct, int receiver_pct, int n_beats);
    int counted;
    int seg_len;
    int vec_len;
    int unsigned wa, wb;
    bit known;
    logic [COUNT_W-1:0] cnt;
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    counted = 0;
    while (counted < n_beats) begin
      if ($urandom_range(0, 19) < 2)
        write_pair_mode(PAIR_MODE_W'($urandom_range(MODE_UNDEF_LO, MODE_UNDEF_HI)));
      else
        write_pair_mode(PAIR_MODE_W'($urandom_range(MODE_16X16, MODE_4X2)));
      mode_widths(pair_mode_q, wa, wb, known);
      seg_len = $urandom_range(40, 80);
      while (seg_len > 0) begin
        vec_len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 6) : $urandom_range(7, 40);
        for (int k = 0; k < vec_len; k++) begin
          if ($urandom_range(0, 15) < 12) cnt = COUNT_W'($urandom_range(1, 4));
          else cnt = COUNT_W'($urandom_range(0, 7));
          send_beat(rand_word(known ? wa : 16), rand_word(known ? wb : 16), cnt,
                    k == vec_len - 1);
          counted++;
        end
        seg_len -= vec_len;
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    push          = 1'b0;
    a_bits_i      = '0;
    b_bits_i      = '0;
    valid_count_i = '0;
    last_i        = 1'b0;
    pair_mode_q   = MODE_16X16;
    running_sum_q = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    fail_count    = 0;
    beats_sent    = 0;
    sums_checked  = 0;
    mode_writes   = 0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_default();
    test_each_pair_mode();
    test_operand_extremes();
    test_undefined_modes();
    test_random_vectors(9, 64, 450);
    test_random_vectors(64, 9, 450);
    test_random_vectors(0, 0, 450);

    push <= 1'b0;
    while (expected_sums.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);

    $display("Sent %0d beats over all ten pair modes and the undefined codes, %0d mode writes.",
             beats_sent, mode_writes);
    $display("Checked %0d sums under light, heavy and no back-pressure; %0d failures.",
             sums_checked, fail_count);
    if (fail_count == 0) begin
      $display("packed_mixed_dot_product regression: pass");
    end else begin
      $display("packed_mixed_dot_product regression: fail");
    end
    $finish;
  end

endmodule
